@@ src/mks_pkg.sv @@
// Shared types, constants, case folding and Morse ROM of the keying sequencer.
package mks_pkg;

  localparam int unsigned TICK_W       = 24;
  localparam int unsigned DUR_W        = 26;
  localparam int unsigned CS_W         = 2;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned MAX_ELEMENTS = 7;
  localparam int unsigned PAT_W        = 8;
  localparam int unsigned LEN_W        = $clog2(PAT_W + 1);
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);
  localparam int unsigned APB_DW       = 32;
  localparam int unsigned APB_AW       = 4;

  localparam logic [CHAR_W-1:0] HIGH_START = 8'h80;
  localparam logic [CHAR_W-1:0] CHR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CHR_LF     = 8'h0A;

  localparam logic [CS_W-1:0] CS_NONE   = 2'd0;
  localparam logic [CS_W-1:0] CS_LATIN1 = 2'd1;
  localparam logic [CS_W-1:0] CS_GREEK  = 2'd2;
  localparam logic [CS_W-1:0] CS_KOI8R  = 2'd3;

  localparam logic [1:0] REG_DOT     = 2'd0;
  localparam logic [1:0] REG_SPACING = 2'd1;
  localparam logic [1:0] REG_CHARSET = 2'd2;

  localparam logic [TICK_W-1:0] DOT_RESET     = 24'd30;
  localparam logic [TICK_W-1:0] SPACING_RESET = 24'd30;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SPACE_WORD,
    BK_SPACE_DOT,
    BK_ON,
    BK_OFF,
    BK_GAP
  } bk_state_e;

  // dash holds the pattern left-aligned, one bit per element, 1 for a dash
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] dash;
  } rom_t;

  typedef struct packed {
    logic             is_space;
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] dash;
  } desc_t;

  function automatic logic [CHAR_W-1:0] mks_fold(logic [CHAR_W-1:0] c, logic [CS_W-1:0] cs);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end else if (cs == CS_LATIN1) begin
      if (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7) r = c + 8'h20;
    end else if (cs == CS_GREEK) begin
      if (c >= 8'hC1 && c <= 8'hDB && c != 8'hD2) r = c + 8'h20;
      else if (c == 8'hB6) r = 8'hDC;
      else if (c >= 8'hB8 && c <= 8'hBA) r = c + 8'h25;
      else if (c == 8'hBC) r = 8'hFC;
      else if (c == 8'hBE || c == 8'hBF) r = c + 8'h3F;
    end else if (cs == CS_KOI8R) begin
      if (c >= 8'hE0) r = c - 8'h20;
      else if (c == 8'hB3) r = 8'hA3;
    end
    return r;
  endfunction

  function automatic rom_t rom_ascii(logic [CHAR_W-1:0] c);
    rom_t r;
    unique case (c) inside
      8'h61: r = {4'd2, 8'b01000000};
      8'h62: r = {4'd4, 8'b10000000};
      8'h63: r = {4'd4, 8'b10100000};
      8'h64: r = {4'd3, 8'b10000000};
      8'h65: r = {4'd1, 8'b00000000};
      8'h66: r = {4'd4, 8'b00100000};
      8'h67: r = {4'd3, 8'b11000000};
      8'h68: r = {4'd4, 8'b00000000};
      8'h69: r = {4'd2, 8'b00000000};
      8'h6A: r = {4'd4, 8'b01110000};
      8'h6B: r = {4'd3, 8'b10100000};
      8'h6C: r = {4'd4, 8'b01000000};
      8'h6D: r = {4'd2, 8'b11000000};
      8'h6E: r = {4'd2, 8'b10000000};
      8'h6F: r = {4'd3, 8'b11100000};
      8'h70: r = {4'd4, 8'b01100000};
      8'h71: r = {4'd4, 8'b11010000};
      8'h72: r = {4'd3, 8'b01000000};
      8'h73: r = {4'd3, 8'b00000000};
      8'h74: r = {4'd1, 8'b10000000};
      8'h75: r = {4'd3, 8'b00100000};
      8'h76: r = {4'd4, 8'b00010000};
      8'h77: r = {4'd3, 8'b01100000};
      8'h78: r = {4'd4, 8'b10010000};
      8'h79: r = {4'd4, 8'b10110000};
      8'h7A: r = {4'd4, 8'b11000000};
      8'h30: r = {4'd5, 8'b11111000};
      8'h31: r = {4'd5, 8'b01111000};
      8'h32: r = {4'd5, 8'b00111000};
      8'h33: r = {4'd5, 8'b00011000};
      8'h34: r = {4'd5, 8'b00001000};
      8'h35: r = {4'd5, 8'b00000000};
      8'h36: r = {4'd5, 8'b10000000};
      8'h37: r = {4'd5, 8'b11000000};
      8'h38: r = {4'd5, 8'b11100000};
      8'h39: r = {4'd5, 8'b11110000};
      8'h2C: r = {4'd6, 8'b11001100};
      8'h2E: r = {4'd6, 8'b01010100};
      8'h22: r = {4'd6, 8'b01001000};
      8'h21: r = {4'd5, 8'b00110000};
      8'h3F: r = {4'd6, 8'b00110000};
      8'h2F: r = {4'd5, 8'b10010000};
      8'h2D: r = {4'd6, 8'b10000100};
      8'h3D: r = {4'd5, 8'b10001000};
      8'h3A: r = {4'd6, 8'b11100000};
      8'h3B: r = {4'd6, 8'b10101000};
      8'h28: r = {4'd5, 8'b10110000};
      8'h29: r = {4'd6, 8'b10110100};
      8'h24: r = {4'd7, 8'b00010010};
      8'h2B: r = {4'd5, 8'b01010000};
      8'h40: r = {4'd6, 8'b01101000};
      8'h23: r = {4'd5, 8'b01000000};
      8'h26: r = {4'd6, 8'b00010100};
      8'h2A: r = {4'd5, 8'b00010000};
      8'h25: r = {4'd7, 8'b10001010};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rom_t rom_latin1(logic [CHAR_W-1:0] c);
    rom_t r;
    unique case (c) inside
      8'hE0, 8'hE1, 8'hE2: r = {4'd5, 8'b01101000};
      8'hE4:               r = {4'd4, 8'b01010000};
      8'hE7:               r = {4'd5, 8'b10100000};
      8'hE8, 8'hE9:        r = {4'd5, 8'b00100000};
      8'hEA:               r = {4'd5, 8'b10010000};
      8'hF6:               r = {4'd4, 8'b11100000};
      8'hFC:               r = {4'd4, 8'b00110000};
      default:             r = '0;
    endcase
    return r;
  endfunction

  function automatic rom_t rom_greek(logic [CHAR_W-1:0] c);
    rom_t r;
    unique case (c) inside
      8'hE1, 8'hDC:               r = {4'd2, 8'b01000000};
      8'hE2:                      r = {4'd4, 8'b10000000};
      8'hE3:                      r = {4'd3, 8'b11000000};
      8'hE4:                      r = {4'd3, 8'b10000000};
      8'hE5, 8'hDD:               r = {4'd1, 8'b00000000};
      8'hE6:                      r = {4'd4, 8'b11000000};
      8'hE7, 8'hDE:               r = {4'd4, 8'b00000000};
      8'hE8:                      r = {4'd4, 8'b10100000};
      8'hE9, 8'hDF, 8'hFA, 8'hC0: r = {4'd2, 8'b00000000};
      8'hEA:                      r = {4'd3, 8'b10100000};
      8'hEB:                      r = {4'd4, 8'b01000000};
      8'hEC:                      r = {4'd2, 8'b11000000};
      8'hED:                      r = {4'd2, 8'b10000000};
      8'hEE:                      r = {4'd4, 8'b10010000};
      8'hEF, 8'hFC:               r = {4'd3, 8'b11100000};
      8'hF0:                      r = {4'd4, 8'b01100000};
      8'hF1:                      r = {4'd3, 8'b01000000};
      8'hF3, 8'hF2:               r = {4'd3, 8'b00000000};
      8'hF4:                      r = {4'd1, 8'b10000000};
      8'hF5, 8'hFD, 8'hFB, 8'hE0: r = {4'd4, 8'b10110000};
      8'hF6:                      r = {4'd4, 8'b00100000};
      8'hF7:                      r = {4'd4, 8'b11110000};
      8'hF8:                      r = {4'd4, 8'b11010000};
      8'hF9, 8'hFE:               r = {4'd3, 8'b01100000};
      default:                    r = '0;
    endcase
    return r;
  endfunction

  function automatic rom_t rom_koi8r(logic [CHAR_W-1:0] c);
    rom_t r;
    unique case (c) inside
      8'hC1:        r = {4'd2, 8'b01000000};
      8'hC2:        r = {4'd4, 8'b10000000};
      8'hD7:        r = {4'd3, 8'b01100000};
      8'hC7:        r = {4'd3, 8'b11000000};
      8'hC4:        r = {4'd3, 8'b10000000};
      8'hC5, 8'hA3: r = {4'd1, 8'b00000000};
      8'hD6:        r = {4'd4, 8'b00010000};
      8'hDA:        r = {4'd4, 8'b11000000};
      8'hC9:        r = {4'd2, 8'b00000000};
      8'hCA:        r = {4'd4, 8'b01110000};
      8'hCB:        r = {4'd3, 8'b10100000};
      8'hCC:        r = {4'd4, 8'b01000000};
      8'hCD:        r = {4'd2, 8'b11000000};
      8'hCE:        r = {4'd2, 8'b10000000};
      8'hCF:        r = {4'd3, 8'b11100000};
      8'hD0:        r = {4'd4, 8'b01100000};
      8'hD2:        r = {4'd3, 8'b01000000};
      8'hD3:        r = {4'd3, 8'b00000000};
      8'hD4:        r = {4'd1, 8'b10000000};
      8'hD5:        r = {4'd3, 8'b00100000};
      8'hC6:        r = {4'd4, 8'b00100000};
      8'hC8:        r = {4'd4, 8'b00000000};
      8'hC3:        r = {4'd4, 8'b10100000};
      8'hDE:        r = {4'd4, 8'b11100000};
      8'hDB:        r = {4'd4, 8'b11110000};
      8'hDD:        r = {4'd4, 8'b11010000};
      8'hD9:        r = {4'd4, 8'b10110000};
      8'hD8:        r = {4'd4, 8'b10010000};
      8'hDC:        r = {4'd5, 8'b00100000};
      8'hC0:        r = {4'd4, 8'b00110000};
      8'hD1:        r = {4'd4, 8'b01010000};
      default:      r = '0;
    endcase
    return r;
  endfunction

  function automatic rom_t mks_lookup(logic [CHAR_W-1:0] c, logic [CS_W-1:0] cs);
    rom_t r;
    if (c < HIGH_START) begin
      r = rom_ascii(c);
    end else begin
      unique case (cs)
        CS_LATIN1: r = rom_latin1(c);
        CS_GREEK:  r = rom_greek(c);
        CS_KOI8R:  r = rom_koi8r(c);
        default:   r = '0;
      endcase
    end
    if (r.len > LEN_W'(MAX_ELEMENTS)) r.len = LEN_W'(MAX_ELEMENTS);
    return r;
  endfunction

endpackage

@@ src/morse_keying_sequencer.sv @@
// Top level of the Morse keying sequencer: register port, front end, queue and sequencer.
//
// Input channel: write a character byte on char_code_i with push; it is taken at a
// clock edge where push is high and full is low. Unknown bytes are dropped.
// Result channel: while empty is low, key_on_o, duration_ticks_o and last_o show the
// oldest keying segment; pop takes it. last_o marks the closing segment of a character.
// A character of n elements gives 2n+1 segments, a space, CR or LF gives three.
// The first segment of a character reaches the ports through the queue, the sequencer's
// idle state, where its descriptor is loaded, and the output register.
// The sequencer loads a descriptor in its idle state and then emits one segment per
// cycle while pop does not hold it; it loads the next one after the closing segment.
// A two-entry descriptor queue lets the input side run ahead of the sequencer.
// When the receiver holds pop low the segment stays put, the sequencer stops and the
// queue fills; full then rises. Nothing is lost.
// Registers (APB, byte address 4*i): dot_ticks, spacing_ticks, charset_select.
// Write them only while the block is idle.
// Reset: registers return to 30, 30 and 0; queue and output register are emptied.
module morse_keying_sequencer import mks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [CHAR_W-1:0] char_code_i,
  output logic              empty,
  input  logic              pop,
  output logic              key_on_o,
  output logic [DUR_W-1:0]  duration_ticks_o,
  output logic              last_o
);

  logic [TICK_W-1:0] dot_q, dot_d;
  logic [TICK_W-1:0] spacing_q, spacing_d;
  logic [CS_W-1:0]   charset_q, charset_d;
  logic              wr_en;
  logic [1:0]        reg_idx;

  logic              q_wr;
  desc_t             q_wdata;
  logic              q_rd;
  desc_t             q_rdata;
  logic              q_full;
  logic              q_empty;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    dot_d     = dot_q;
    spacing_d = spacing_q;
    charset_d = charset_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DOT:     dot_d     = pwdata[TICK_W-1:0];
        REG_SPACING: spacing_d = pwdata[TICK_W-1:0];
        REG_CHARSET: charset_d = pwdata[CS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DOT:     prdata = APB_DW'(dot_q);
      REG_SPACING: prdata = APB_DW'(spacing_q);
      REG_CHARSET: prdata = APB_DW'(charset_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q     <= DOT_RESET;
      spacing_q <= SPACING_RESET;
      charset_q <= CS_NONE;
    end else begin
      dot_q     <= dot_d;
      spacing_q <= spacing_d;
      charset_q <= charset_d;
    end
  end

  assign full = q_full;

  mks_front u_front (
    .push_i      (push),
    .char_code_i (char_code_i),
    .charset_i   (charset_q),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_wdata_o   (q_wdata)
  );

  mks_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mks_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_rdata_i        (q_rdata),
    .q_empty_i        (q_empty),
    .q_rd_o           (q_rd),
    .dot_ticks_i      (dot_q),
    .spacing_ticks_i  (spacing_q),
    .empty_o          (empty),
    .pop_i            (pop),
    .key_on_o         (key_on_o),
    .duration_ticks_o (duration_ticks_o),
    .last_o           (last_o)
  );

endmodule

@@ src/mks_front.sv @@
// Front end: folds and classifies each character into a segment descriptor.
module mks_front import mks_pkg::*; (
  input  logic              push_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [CS_W-1:0]   charset_i,
  input  logic              q_full_i,
  output logic              q_wr_o,
  output desc_t             q_wdata_o
);

  logic [CHAR_W-1:0] folded;
  logic              is_space;
  rom_t              rom;

  always_comb begin
    folded   = mks_fold(char_code_i, charset_i);
    is_space = (folded == CHR_SPACE) || (folded == CHR_CR) || (folded == CHR_LF);
    rom      = mks_lookup(folded, charset_i);
  end

  // drop unknown characters: they give no segment at all
  assign q_wdata_o.is_space = is_space;
  assign q_wdata_o.len      = rom.len;
  assign q_wdata_o.dash     = rom.dash;
  assign q_wr_o             = push_i && !q_full_i && (is_space || (rom.len != '0));

endmodule

@@ src/mks_queue.sv @@
// Short descriptor queue between front end and sequencer.
module mks_queue import mks_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  desc_t wdata_i,
  input  logic  rd_i,
  output desc_t rdata_o,
  output logic  full_o,
  output logic  empty_o
);

  desc_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) cnt_d = cnt_q + 1'b1;
    else if (rd_i && !wr_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

@@ src/mks_back.sv @@
// Sequencer: turns descriptors into keying segments behind an output register.
module mks_back import mks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  desc_t             q_rdata_i,
  input  logic              q_empty_i,
  output logic              q_rd_o,
  input  logic [TICK_W-1:0] dot_ticks_i,
  input  logic [TICK_W-1:0] spacing_ticks_i,
  output logic              empty_o,
  input  logic              pop_i,
  output logic              key_on_o,
  output logic [DUR_W-1:0]  duration_ticks_o,
  output logic              last_o
);

  bk_state_e         state_q, state_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [PAT_W-1:0]  pat_q, pat_d;
  logic              out_valid_q, out_valid_d;
  logic              key_q;
  logic [DUR_W-1:0]  dur_q;
  logic              last_q;

  logic              can_emit;
  logic              seg_emit;
  logic              seg_key;
  logic [DUR_W-1:0]  seg_dur;
  logic              seg_last;
  logic [DUR_W-1:0]  dot1, dot3, sp3;

  assign can_emit = !out_valid_q || pop_i;
  assign dot1     = DUR_W'(dot_ticks_i);
  assign dot3     = DUR_W'(dot_ticks_i) + DUR_W'({dot_ticks_i, 1'b0});
  assign sp3      = DUR_W'(spacing_ticks_i) + DUR_W'({spacing_ticks_i, 1'b0});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_rdata_i.is_space) state_d = BK_SPACE_WORD;
          else if (q_rdata_i.len == '0) state_d = BK_GAP;
          else state_d = BK_ON;
        end
      end
      BK_SPACE_WORD: if (can_emit) state_d = BK_SPACE_DOT;
      BK_SPACE_DOT:  if (can_emit) state_d = BK_GAP;
      BK_ON:         if (can_emit) state_d = BK_OFF;
      BK_OFF: begin
        if (can_emit) state_d = (rem_q == LEN_W'(1)) ? BK_GAP : BK_ON;
      end
      BK_GAP:        if (can_emit) state_d = BK_IDLE;
      default:       state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_rd_o   = 1'b0;
    seg_emit = 1'b0;
    seg_key  = 1'b0;
    seg_dur  = dot1;
    seg_last = 1'b0;
    rem_d    = rem_q;
    pat_d    = pat_q;
    unique case (state_q)
      BK_IDLE: begin
        q_rd_o = !q_empty_i;
        if (!q_empty_i) begin
          rem_d = q_rdata_i.len;
          pat_d = q_rdata_i.dash;
        end
      end
      BK_SPACE_WORD: begin
        seg_emit = can_emit;
        seg_dur  = sp3;
      end
      BK_SPACE_DOT: begin
        seg_emit = can_emit;
      end
      BK_ON: begin
        seg_emit = can_emit;
        seg_key  = 1'b1;
        seg_dur  = pat_q[PAT_W-1] ? dot3 : dot1;
      end
      BK_OFF: begin
        seg_emit = can_emit;
        if (can_emit) begin
          rem_d = rem_q - 1'b1;
          pat_d = {pat_q[PAT_W-2:0], 1'b0};
        end
      end
      BK_GAP: begin
        seg_emit = can_emit;
        seg_dur  = sp3;
        seg_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_d = seg_emit || (out_valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    if (seg_emit) begin
      key_q  <= seg_key;
      dur_q  <= seg_dur;
      last_q <= seg_last;
    end
  end

  assign empty_o          = !out_valid_q;
  assign key_on_o         = key_q;
  assign duration_ticks_o = dur_q;
  assign last_o           = last_q;

  a_elem_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ON || state_q == BK_OFF) |-> rem_q != '0)
    else $error("element state with no elements left");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(dur_q) && $stable(last_q)))
    else $error("waiting segment lost or changed");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE && !q_empty_i) |=> state_q != BK_IDLE)
    else $error("descriptor taken but sequencer idle");

endmodule
